@@ src/udpdx_pkg.sv @@
// ----------------------------------------------------------------------------
// udpdx_pkg
// Shared types and constants for the UDP socket demux table.
// ----------------------------------------------------------------------------
package udpdx_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [15:0] HDR_BYTES = 16'd8;
	localparam logic [15:0] EPH_FIRST = 16'd49152;
	localparam logic [15:0] EPH_LAST  = 16'hFFFF;
	localparam logic [7:0]  LIMIT_RST = 8'd16;

	// operation kinds
	localparam logic [2:0] K_OPEN    = 3'd0;
	localparam logic [2:0] K_CLOSE   = 3'd1;
	localparam logic [2:0] K_BIND    = 3'd2;
	localparam logic [2:0] K_CONNECT = 3'd3;
	localparam logic [2:0] K_DELIVER = 3'd4;
	localparam logic [2:0] K_DEQUEUE = 3'd5;

	// status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_BADMSG  = 3'd1;
	localparam logic [2:0] STAT_REFUSED = 3'd2;
	localparam logic [2:0] STAT_NOBUFS  = 3'd3;
	localparam logic [2:0] STAT_INVALID = 3'd4;
	localparam logic [2:0] STAT_INUSE   = 3'd5;
	localparam logic [2:0] STAT_FULL    = 3'd6;
	localparam logic [2:0] STAT_EMPTY   = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] peer_address;
		logic [31:0] host_address;
		logic [15:0] peer_port;
		logic [15:0] host_port;
		logic [15:0] length_field;
		logic [15:0] buffer_length;
		logic        checksum_nonzero;
		logic        checksum_verified;
	} item_t;

	// classified command: item plus header check verdict
	typedef struct packed {
		item_t item;
		logic  hdr_ok;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  result_slot;
		logic [15:0] bound_port;
		logic [15:0] data_length;
		logic [7:0]  queue_count;
	} res_t;

	typedef struct packed {
		logic        open;
		logic        bound;
		logic [31:0] laddr;
		logic [15:0] lport;
		logic [31:0] raddr;
		logic [15:0] rport;
		logic [7:0]  qcnt;
	} slot_t;

endpackage

@@ src/udpdx_front.sv @@
// ----------------------------------------------------------------------------
// udpdx_front
// Accepts items, checks the UDP header, and holds them in a two-beat queue.
// ----------------------------------------------------------------------------
module udpdx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  udpdx_pkg::item_t in_item,
	output logic             cmd_valid,
	output udpdx_pkg::cmd_t  cmd,
	input  logic             cmd_take
);
	import udpdx_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       hdr_ok;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		hdr_ok = (in_item.buffer_length >= HDR_BYTES) && (in_item.peer_port != 16'd0) &&
			(in_item.host_port != 16'd0) && (in_item.length_field >= HDR_BYTES) &&
			(in_item.length_field <= in_item.buffer_length) &&
			!(in_item.checksum_nonzero && !in_item.checksum_verified);
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= '{item: in_item, hdr_ok: hdr_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

@@ src/udpdx_back.sv @@
// ----------------------------------------------------------------------------
// udpdx_back
// Executes commands against the endpoint table; results go to a two-beat queue.
// ----------------------------------------------------------------------------
module udpdx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  udpdx_pkg::cmd_t cmd,
	output logic            cmd_take,
	input  logic [7:0]      limit,
	output logic            empty,
	input  logic            pop,
	output udpdx_pkg::res_t res
);
	import udpdx_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_AUTO = 2'd2;

	logic [1:0]  state_q, state_d;
	cmd_t        cmd_q;
	slot_t       slot_q [SLOTS];
	logic [15:0] eph_q, eph_d;
	logic [13:0] tries_q, tries_d;

	res_t        out_q [2];
	logic        owr_q, ord_q;
	logic [1:0]  ocnt_q;
	logic        res_we;
	res_t        res_d;

	logic        upd_en;
	slot_t       cur, upd;
	logic [SLOT_W-1:0] upd_idx;

	logic              free_hit, match_hit, bind_clash, auto_clash;
	logic [SLOT_W-1:0] free_idx, match_idx;
	slot_t             mslot;
	item_t             it;

	assign it  = cmd_q.item;
	assign cur = slot_q[it.slot[SLOT_W-1:0]];

	// parallel scans over the table
	always_comb begin
		free_hit   = 1'b0;
		free_idx   = '0;
		match_hit  = 1'b0;
		match_idx  = '0;
		bind_clash = 1'b0;
		auto_clash = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_q[i].open && !free_hit) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
			if (!match_hit && slot_q[i].open && slot_q[i].bound &&
				slot_q[i].lport == it.host_port &&
				(slot_q[i].laddr == 32'd0 || slot_q[i].laddr == it.host_address) &&
				(slot_q[i].raddr == 32'd0 || (slot_q[i].raddr == it.peer_address &&
				slot_q[i].rport == it.peer_port))) begin
				match_hit = 1'b1;
				match_idx = SLOT_W'(i);
			end
			if (SLOT_W'(i) != it.slot[SLOT_W-1:0] && slot_q[i].open && slot_q[i].bound) begin
				if (slot_q[i].lport == it.host_port && (slot_q[i].laddr == 32'd0 ||
					it.host_address == 32'd0 || slot_q[i].laddr == it.host_address)) begin
					bind_clash = 1'b1;
				end
				if (slot_q[i].lport == eph_q) begin
					auto_clash = 1'b1;
				end
			end
		end
	end

	assign mslot = slot_q[match_idx];

	always_comb begin
		state_d  = state_q;
		eph_d    = eph_q;
		tries_d  = tries_q;
		cmd_take = 1'b0;
		res_we   = 1'b0;
		res_d    = '0;
		upd_en   = 1'b0;
		upd_idx  = it.slot[SLOT_W-1:0];
		upd      = cur;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && ocnt_q != 2'd2) begin
					cmd_take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				res_we        = 1'b1;
				state_d       = S_IDLE;
				res_d.status  = STAT_INVALID;
				case (it.kind)
					K_OPEN: begin
						if (free_hit) begin
							upd_en            = 1'b1;
							upd_idx           = free_idx;
							upd               = '0;
							upd.open          = 1'b1;
							res_d.status      = STAT_OK;
							res_d.result_slot = 4'(free_idx);
						end else begin
							res_d.status = STAT_FULL;
						end
					end
					K_DELIVER: begin
						if (!cmd_q.hdr_ok) begin
							res_d.status = STAT_BADMSG;
						end else if (!match_hit) begin
							res_d.status = STAT_REFUSED;
						end else begin
							upd_idx           = match_idx;
							upd               = mslot;
							res_d.result_slot = 4'(match_idx);
							if (mslot.qcnt >= limit) begin
								res_d.status = STAT_NOBUFS;
							end else begin
								upd_en            = 1'b1;
								upd.qcnt          = mslot.qcnt + 8'd1;
								res_d.status      = STAT_OK;
								res_d.data_length = it.length_field - HDR_BYTES;
							end
							res_d.bound_port  = upd.lport;
							res_d.queue_count = upd.qcnt;
						end
					end
					K_CLOSE, K_BIND, K_CONNECT, K_DEQUEUE: begin
						if (cur.open) begin
							res_d.result_slot = it.slot;
							case (it.kind)
								K_CLOSE: begin
									upd_en       = 1'b1;
									upd          = '0;
									res_d.status = STAT_OK;
								end
								K_BIND: begin
									if (it.host_port == 16'd0) begin
										res_d.status = STAT_INVALID;
									end else if (bind_clash) begin
										res_d.status = STAT_INUSE;
									end else begin
										upd_en       = 1'b1;
										upd.laddr    = it.host_address;
										upd.lport    = it.host_port;
										upd.bound    = 1'b1;
										res_d.status = STAT_OK;
									end
								end
								K_CONNECT: begin
									if (it.peer_address == 32'd0 || it.peer_port == 16'd0) begin
										res_d.status = STAT_INVALID;
									end else if (cur.bound) begin
										upd_en       = 1'b1;
										upd.raddr    = it.peer_address;
										upd.rport    = it.peer_port;
										res_d.status = STAT_OK;
									end else begin
										// hunt for a free ephemeral port
										res_we  = 1'b0;
										tries_d = '0;
										state_d = S_AUTO;
									end
								end
								default: begin
									if (cur.qcnt == 8'd0) begin
										res_d.status = STAT_EMPTY;
									end else begin
										upd_en       = 1'b1;
										upd.qcnt     = cur.qcnt - 8'd1;
										res_d.status = STAT_OK;
									end
								end
							endcase
							res_d.bound_port  = upd.lport;
							res_d.queue_count = upd.qcnt;
						end
					end
					default: begin
						res_d.status = STAT_INVALID;
					end
				endcase
			end
			S_AUTO: begin
				eph_d             = (eph_q == EPH_LAST) ? EPH_FIRST : eph_q + 16'd1;
				res_d.result_slot = it.slot;
				res_d.queue_count = cur.qcnt;
				if (!auto_clash) begin
					upd_en           = 1'b1;
					upd.lport        = eph_q;
					upd.bound        = 1'b1;
					upd.raddr        = it.peer_address;
					upd.rport        = it.peer_port;
					res_we           = 1'b1;
					res_d.status     = STAT_OK;
					res_d.bound_port = eph_q;
					state_d          = S_IDLE;
				end else if (tries_q == '1) begin
					res_we           = 1'b1;
					res_d.status     = STAT_INUSE;
					res_d.bound_port = cur.lport;
					state_d          = S_IDLE;
				end else begin
					tries_d = tries_q + 14'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (res_we) begin
			out_q[owr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eph_q   <= EPH_FIRST;
			tries_q <= '0;
			owr_q   <= 1'b0;
			ord_q   <= 1'b0;
			ocnt_q  <= 2'd0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			eph_q   <= eph_d;
			tries_q <= tries_d;
			if (upd_en) begin
				slot_q[upd_idx] <= upd;
			end
			if (res_we) begin
				owr_q <= !owr_q;
			end
			if (pop && !empty) begin
				ord_q <= !ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, res_we} - {1'b0, pop && !empty};
		end
	end

	assign empty = (ocnt_q == 2'd0);
	assign res   = out_q[ord_q];

endmodule

@@ src/udp_socket_demux_table_top.sv @@
// ----------------------------------------------------------------------------
// udp_socket_demux_table_top
// UDP endpoint table: open, close, bind, connect, deliver and dequeue.
// ----------------------------------------------------------------------------
// One operation per input beat, one result beat per operation, in order.
// Each operation is fetched from the command queue by the execute unit, then
// resolved by a parallel scan of all 16 slots. A connect on an unbound slot
// tries ephemeral ports one at a time (from 49152 up, wrapping); with 16 slots
// at most 16 tries are needed, bounded by 16384. Input and result sides each
// have a two-beat queue, so a result waiting on pop does not block new input.
// rx_queue_limit is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle; the block has no check. Reset value is 16.
// ----------------------------------------------------------------------------
module udp_socket_demux_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [3:0]  slot,
	input  logic [31:0] peer_address,
	input  logic [31:0] host_address,
	input  logic [15:0] peer_port,
	input  logic [15:0] host_port,
	input  logic [15:0] length_field,
	input  logic [15:0] buffer_length,
	input  logic        checksum_nonzero,
	input  logic        checksum_verified,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [3:0]  result_slot,
	output logic [15:0] bound_port,
	output logic [15:0] data_length,
	output logic [7:0]  queue_count
);
	import udpdx_pkg::*;

	item_t      in_item;
	cmd_t       cmd;
	logic       cmd_valid;
	logic       cmd_take;
	res_t       res;
	logic [7:0] limit_q;

	// rx queue limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign in_item = '{kind: kind, slot: slot, peer_address: peer_address,
		host_address: host_address, peer_port: peer_port, host_port: host_port,
		length_field: length_field, buffer_length: buffer_length,
		checksum_nonzero: checksum_nonzero, checksum_verified: checksum_verified};

	// front: header check and command queue
	udpdx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// back: table execution and result queue
	udpdx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.limit     (limit_q),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign status      = res.status;
	assign result_slot = res.result_slot;
	assign bound_port  = res.bound_port;
	assign data_length = res.data_length;
	assign queue_count = res.queue_count;

endmodule
